FILE: rtl/tpc_pkg.sv
`timescale 1ns / 1ps

package tpc_pkg;

   // Defaults for the top-level parameters
   localparam int NODE_COUNT_DEFAULT     = 1024;
   localparam int ALPHABET_SIZE_DEFAULT  = 26;
   localparam int MAX_KEY_LENGTH_DEFAULT = 10;
   localparam int COUNT_WIDTH_DEFAULT    = 16;

   // Fixed field geometry
   localparam int LETTER_BITS    = 5;
   localparam int KEY_CHARS_W    = 50;
   localparam int KEY_LENGTH_W   = 4;
   localparam int PREFIX_COUNT_W = 16;

   localparam logic MODE_INSERT = 1'b0;
   localparam logic MODE_QUERY  = 1'b1;

   localparam logic KIND_ANSWER = 1'b0;
   localparam logic KIND_REJECT = 1'b1;

   typedef logic [LETTER_BITS-1:0] letter_type;

   // Controller -> datapath
   typedef struct packed {
      logic load_item;   // latch request, walk starts at the root
      logic calc_addr;   // link address from node and current letter
      logic alloc;       // new child: link it, count 1, step down
      logic follow;      // existing child: step down, count read issued
      logic count_inc;   // write back incremented count of current node
      logic clear_wr;    // zero one link entry of the clearing sweep
      logic post;        // load the result register
      logic post_kind;
      logic post_count;  // 1: count read data, 0: zero
   } tpc_cmd_type;

   // Datapath -> controller
   typedef struct packed {
      logic mode;
      logic len_zero;
      logic letters_bad;
      logic no_room;
      logic link_zero;
      logic last_level;
      logic clear_done;
      logic rsp_free;
   } tpc_status_type;

endpackage

FILE: rtl/tpc_if.sv
`timescale 1ns / 1ps

interface tpc_req_if;
   import tpc_pkg::*;
   logic                    valid;
   logic                    ready;
   logic                    mode;
   logic [KEY_CHARS_W-1:0]  key_chars;
   logic [KEY_LENGTH_W-1:0] key_length;

   modport source (output valid, mode, key_chars, key_length, input ready);
   modport sink   (input valid, mode, key_chars, key_length, output ready);
endinterface

interface tpc_rsp_if;
   import tpc_pkg::*;
   logic                      valid;
   logic                      ready;
   logic                      kind;
   logic [PREFIX_COUNT_W-1:0] prefix_count;

   modport source (output valid, kind, prefix_count, input ready);
   modport sink   (input valid, kind, prefix_count, output ready);
endinterface

FILE: rtl/tpc_ram.sv
`timescale 1ns / 1ps

module tpc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/tpc_ctrl.sv
`timescale 1ns / 1ps

module tpc_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  tpc_pkg::tpc_status_type status,
   output tpc_pkg::tpc_cmd_type    cmd
);
   import tpc_pkg::*;

   localparam logic [3:0] S_CLEAR  = 4'd0;
   localparam logic [3:0] S_IDLE   = 4'd1;
   localparam logic [3:0] S_CHECK  = 4'd2;
   localparam logic [3:0] S_CALC   = 4'd3;
   localparam logic [3:0] S_LINK   = 4'd4;
   localparam logic [3:0] S_EVAL   = 4'd5;
   localparam logic [3:0] S_CNT    = 4'd6;
   localparam logic [3:0] S_QREAD  = 4'd7;
   localparam logic [3:0] S_QDATA  = 4'd8;
   localparam logic [3:0] S_ZERO   = 4'd9;
   localparam logic [3:0] S_REJECT = 4'd10;

   logic [3:0] state_ff;
   logic [3:0] state_in;

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_CLEAR: begin
            cmd.clear_wr = 1'b1;
            if (status.clear_done) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.load_item = 1'b1;
               state_in      = S_CHECK;
            end
         end
         S_CHECK: begin
            if (status.mode == MODE_INSERT) begin
               if (status.len_zero || status.letters_bad) begin
                  state_in = S_IDLE;
               end else if (status.no_room) begin
                  state_in = S_REJECT;
               end else begin
                  state_in = S_CALC;
               end
            end else begin
               if (status.len_zero || status.letters_bad) begin
                  state_in = S_ZERO;
               end else begin
                  state_in = S_CALC;
               end
            end
         end
         S_CALC: begin
            cmd.calc_addr = 1'b1;
            state_in      = S_LINK;
         end
         S_LINK: begin
            state_in = S_EVAL;
         end
         S_EVAL: begin
            if (status.link_zero) begin
               if (status.mode == MODE_INSERT) begin
                  cmd.alloc = 1'b1;
                  state_in  = status.last_level ? S_IDLE : S_CALC;
               end else begin
                  state_in = S_ZERO;
               end
            end else begin
               cmd.follow = 1'b1;
               if (status.mode == MODE_INSERT) begin
                  state_in = S_CNT;
               end else begin
                  state_in = status.last_level ? S_QREAD : S_CALC;
               end
            end
         end
         S_CNT: begin
            cmd.count_inc = 1'b1;
            state_in      = status.len_zero ? S_IDLE : S_CALC;
         end
         S_QREAD: begin
            state_in = S_QDATA;
         end
         S_QDATA: begin
            if (status.rsp_free) begin
               cmd.post       = 1'b1;
               cmd.post_kind  = KIND_ANSWER;
               cmd.post_count = 1'b1;
               state_in       = S_IDLE;
            end
         end
         S_ZERO: begin
            if (status.rsp_free) begin
               cmd.post      = 1'b1;
               cmd.post_kind = KIND_ANSWER;
               state_in      = S_IDLE;
            end
         end
         S_REJECT: begin
            if (status.rsp_free) begin
               cmd.post      = 1'b1;
               cmd.post_kind = KIND_REJECT;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

FILE: rtl/tpc_datapath.sv
`timescale 1ns / 1ps

module tpc_datapath #(
   parameter int NODE_COUNT     = tpc_pkg::NODE_COUNT_DEFAULT,
   parameter int ALPHABET_SIZE  = tpc_pkg::ALPHABET_SIZE_DEFAULT,
   parameter int MAX_KEY_LENGTH = tpc_pkg::MAX_KEY_LENGTH_DEFAULT,
   parameter int COUNT_WIDTH    = tpc_pkg::COUNT_WIDTH_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  tpc_pkg::tpc_cmd_type                cmd,
   output tpc_pkg::tpc_status_type             status,
   input  logic                                req_mode,
   input  logic [tpc_pkg::KEY_CHARS_W-1:0]     req_key_chars,
   input  logic [tpc_pkg::KEY_LENGTH_W-1:0]    req_key_length,
   input  logic                                rsp_ready,
   output logic                                rsp_valid,
   output logic                                rsp_kind,
   output logic [tpc_pkg::PREFIX_COUNT_W-1:0]  rsp_prefix_count
);
   import tpc_pkg::*;

   localparam int NODE_W     = $clog2(NODE_COUNT);
   localparam int FREE_W     = NODE_W + 1;
   localparam int ROOM_W     = NODE_W + 2;
   localparam int LINK_DEPTH = NODE_COUNT * ALPHABET_SIZE;
   localparam int LINK_AW    = $clog2(LINK_DEPTH);

   // item and walk registers
   logic                      mode_ff,  mode_in;
   logic [KEY_CHARS_W-1:0]    chars_ff, chars_in;
   logic [KEY_LENGTH_W-1:0]   len_ff,   len_in;
   logic [NODE_W-1:0]         node_ff,  node_in;
   logic [LINK_AW-1:0]        addr_ff,  addr_in;
   // control registers
   logic [FREE_W-1:0]         next_free_ff, next_free_in;
   logic [LINK_AW-1:0]        clr_ff,       clr_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   // result payload
   logic                      rsp_kind_ff,  rsp_kind_in;
   logic [PREFIX_COUNT_W-1:0] rsp_count_ff, rsp_count_in;

   logic [KEY_LENGTH_W-1:0]   len_sat;
   logic                      letters_bad;
   logic                      step;

   logic                      link_wr_en;
   logic [LINK_AW-1:0]        link_wr_addr;
   logic [NODE_W-1:0]         link_wr_data;
   logic [NODE_W-1:0]         link_rdata;

   logic                      count_wr_en;
   logic [NODE_W-1:0]         count_wr_addr;
   logic [COUNT_WIDTH-1:0]    count_wr_data;
   logic [NODE_W-1:0]         count_rd_addr;
   logic [COUNT_WIDTH-1:0]    count_rdata;
   logic [COUNT_WIDTH-1:0]    count_next;
   logic [PREFIX_COUNT_W-1:0] count_clip;

   assign len_sat = (req_key_length > KEY_LENGTH_W'(MAX_KEY_LENGTH))
                  ? KEY_LENGTH_W'(MAX_KEY_LENGTH) : req_key_length;

   always_comb begin
      letters_bad = 1'b0;
      for (int i = 0; i < MAX_KEY_LENGTH; i++) begin
         if ((KEY_LENGTH_W'(i) < len_ff) &&
             ({1'b0, letter_type'(chars_ff >> (LETTER_BITS * i))}
              >= (LETTER_BITS + 1)'(ALPHABET_SIZE))) begin
            letters_bad = 1'b1;
         end
      end
   end

   assign step = cmd.alloc || cmd.follow;

   always_comb begin
      mode_in  = mode_ff;
      chars_in = chars_ff;
      len_in   = len_ff;
      node_in  = node_ff;
      if (cmd.load_item) begin
         mode_in  = req_mode;
         chars_in = req_key_chars;
         len_in   = len_sat;
         node_in  = '0;
      end else if (step) begin
         chars_in = chars_ff >> LETTER_BITS;
         len_in   = len_ff - KEY_LENGTH_W'(1);
         node_in  = cmd.alloc ? next_free_ff[NODE_W-1:0] : link_rdata;
      end
      addr_in = cmd.calc_addr
              ? LINK_AW'(node_ff) * LINK_AW'(ALPHABET_SIZE)
                + LINK_AW'(chars_ff[LETTER_BITS-1:0])
              : addr_ff;
   end

   always_comb begin
      next_free_in = cmd.alloc ? next_free_ff + FREE_W'(1) : next_free_ff;
      clr_in       = cmd.clear_wr ? clr_ff + LINK_AW'(1) : clr_ff;
      rsp_valid_in = cmd.post ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
      rsp_kind_in  = cmd.post ? cmd.post_kind : rsp_kind_ff;
      rsp_count_in = rsp_count_ff;
      if (cmd.post) begin
         rsp_count_in = cmd.post_count ? count_clip : '0;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff      <= mode_in;
      chars_ff     <= chars_in;
      len_ff       <= len_in;
      node_ff      <= node_in;
      addr_ff      <= addr_in;
      rsp_kind_ff  <= rsp_kind_in;
      rsp_count_ff <= rsp_count_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         next_free_ff <= FREE_W'(1);
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         next_free_ff <= next_free_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // child link table
   assign link_wr_en   = cmd.alloc || cmd.clear_wr;
   assign link_wr_addr = cmd.clear_wr ? clr_ff : addr_ff;
   assign link_wr_data = cmd.clear_wr ? '0 : next_free_ff[NODE_W-1:0];

   tpc_ram #(
      .WIDTH (NODE_W),
      .DEPTH (LINK_DEPTH)
   ) u_link_ram (
      .clock   (clock),
      .wr_en   (link_wr_en),
      .wr_addr (link_wr_addr),
      .wr_data (link_wr_data),
      .rd_addr (addr_ff),
      .rd_data (link_rdata)
   );

   // pass counts
   assign count_next    = (&count_rdata) ? count_rdata
                                         : count_rdata + COUNT_WIDTH'(1);
   assign count_wr_en   = cmd.alloc || cmd.count_inc;
   assign count_wr_addr = cmd.alloc ? next_free_ff[NODE_W-1:0] : node_ff;
   assign count_wr_data = cmd.alloc ? COUNT_WIDTH'(1) : count_next;
   assign count_rd_addr = cmd.follow ? link_rdata : node_ff;

   tpc_ram #(
      .WIDTH (COUNT_WIDTH),
      .DEPTH (NODE_COUNT)
   ) u_count_ram (
      .clock   (clock),
      .wr_en   (count_wr_en),
      .wr_addr (count_wr_addr),
      .wr_data (count_wr_data),
      .rd_addr (count_rd_addr),
      .rd_data (count_rdata)
   );

   generate
      if (COUNT_WIDTH > PREFIX_COUNT_W) begin : g_clip
         assign count_clip = (|count_rdata[COUNT_WIDTH-1:PREFIX_COUNT_W])
                           ? '1 : count_rdata[PREFIX_COUNT_W-1:0];
      end else begin : g_extend
         assign count_clip = PREFIX_COUNT_W'(count_rdata);
      end
   endgenerate

   assign status.mode        = mode_ff;
   assign status.len_zero    = (len_ff == '0);
   assign status.letters_bad = letters_bad;
   assign status.no_room     = (ROOM_W'(next_free_ff) + ROOM_W'(len_ff))
                               > ROOM_W'(NODE_COUNT);
   assign status.link_zero   = (link_rdata == '0);
   assign status.last_level  = (len_ff == KEY_LENGTH_W'(1));
   assign status.clear_done  = (clr_ff == LINK_AW'(LINK_DEPTH - 1));
   assign status.rsp_free    = !rsp_valid_ff || rsp_ready;

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_kind         = rsp_kind_ff;
   assign rsp_prefix_count = rsp_count_ff;

endmodule

FILE: rtl/trie_prefix_counter_core.sv
// Prefix-counting trie over a fixed pool of NODE_COUNT nodes.
// req channel: one transfer = one item. mode 0 inserts key_chars/key_length,
//   mode 1 asks how many stored keys start with that prefix.
// rsp channel: one transfer = one result. A query always answers
//   (kind 0, saturated count). An insert answers only when rejected for
//   lack of free nodes (kind 1, count 0); otherwise it is silent.
// Sequencing: items are handled one at a time. After accept and check, each
//   letter steps through link address, link read and evaluate, plus a count
//   write-back when an insert passes an existing node. A query adds a final
//   count read before its result is posted. Each level waits on the
//   registered link memory read.
// Reset: synchronous. Next free node returns to 1 and a clearing sweep
//   zeroes all NODE_COUNT * ALPHABET_SIZE entries of the child link table
//   (26624 at defaults), one entry per cycle; req_ready stays low meanwhile.
// Stall: results sit in an output register, so the next item is accepted
//   while one waits; an item whose result finds the register still full
//   holds in the controller until rsp_ready frees it.
`timescale 1ns / 1ps

module trie_prefix_counter_core #(
   parameter int NODE_COUNT     = tpc_pkg::NODE_COUNT_DEFAULT,
   parameter int ALPHABET_SIZE  = tpc_pkg::ALPHABET_SIZE_DEFAULT,
   parameter int MAX_KEY_LENGTH = tpc_pkg::MAX_KEY_LENGTH_DEFAULT,
   parameter int COUNT_WIDTH    = tpc_pkg::COUNT_WIDTH_DEFAULT
) (
   input  logic      clock,
   input  logic      reset,
   tpc_req_if.sink   req_if,
   tpc_rsp_if.source rsp_if
);
   import tpc_pkg::*;

   tpc_cmd_type    cmd;     // controller strobes for this cycle
   tpc_status_type status;  // datapath flags back to the controller
   logic           req_ready;

   // sequencer: clearing sweep, check, per-level walk, result posting
   tpc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // link table, count table, walk registers and result register
   tpc_datapath #(
      .NODE_COUNT     (NODE_COUNT),
      .ALPHABET_SIZE  (ALPHABET_SIZE),
      .MAX_KEY_LENGTH (MAX_KEY_LENGTH),
      .COUNT_WIDTH    (COUNT_WIDTH)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_mode         (req_if.mode),
      .req_key_chars    (req_if.key_chars),
      .req_key_length   (req_if.key_length),
      .rsp_ready        (rsp_if.ready),
      .rsp_valid        (rsp_if.valid),
      .rsp_kind         (rsp_if.kind),
      .rsp_prefix_count (rsp_if.prefix_count)
   );

   assign req_if.ready = req_ready;

endmodule

FILE: rtl/tpc_checker.sv
`timescale 1ns / 1ps

module tpc_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_valid,
   input logic                               req_ready,
   input logic                               rsp_valid,
   input logic                               rsp_ready,
   input logic                               rsp_kind,
   input logic [tpc_pkg::PREFIX_COUNT_W-1:0] rsp_prefix_count
);
   import tpc_pkg::*;

   // the clearing sweep keeps the input closed right after reset
   a_closed_after_reset: assert property (@(posedge clock)
      reset |=> !req_ready)
      else $error("req_ready high right after reset");

   // one item at a time: input closes after each transfer
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("req_ready stayed high after a transfer");

   a_reject_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind == KIND_REJECT) |-> (rsp_prefix_count == '0))
      else $error("rejected insert carries a nonzero count");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=>
         rsp_valid && $stable(rsp_kind) && $stable(rsp_prefix_count))
      else $error("stalled result changed");

endmodule

bind trie_prefix_counter_core tpc_checker u_tpc_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_if.valid),
   .req_ready        (req_if.ready),
   .rsp_valid        (rsp_if.valid),
   .rsp_ready        (rsp_if.ready),
   .rsp_kind         (rsp_if.kind),
   .rsp_prefix_count (rsp_if.prefix_count)
);

FILE: sim/tb_top.sv
`timescale 1ns / 1ps

// Testbench for trie_prefix_counter_core.
// Inserts and prefix queries are driven on the req channel. A trie copy kept
// here is advanced at every accepted req transfer and queues the answer the
// core owes. Each rsp transfer is checked field by field against the oldest
// queued answer. Both channels idle at random. The run covers an empty trie
// after the clearing sweep, the field extremes, random traffic built from
// stored keys, a long rsp hold-off, repeated inserts of one key and an
// exhausted node pool.
module tb_top;
   import tpc_pkg::*;

   localparam int NODES        = NODE_COUNT_DEFAULT;
   localparam int ALPHA        = ALPHABET_SIZE_DEFAULT;
   localparam int MAX_LEN      = MAX_KEY_LENGTH_DEFAULT;
   localparam int TALLY_MAX    = (1 << COUNT_WIDTH_DEFAULT) - 1;
   localparam int LINK_W       = $clog2(NODES);
   localparam int LETTER_TOP   = (1 << LETTER_BITS) - 1;
   localparam int LEN_TOP      = (1 << KEY_LENGTH_W) - 1;
   localparam int RANDOM_ITEMS = 1200;
   localparam int POOL_RESERVE = 250;    // nodes kept back for the exhaustion test
   localparam int WORD_CAP     = 400;
   localparam int HOLD_CYCLES  = 400;
   localparam int COUNT_REPEAT = 24;
   // The clearing sweep has no transfer on either channel; the limit allows several of those.
   localparam int QUIET_LIMIT  = 120000;

   typedef logic [KEY_CHARS_W-1:0]  chars_type;
   typedef logic [KEY_LENGTH_W-1:0] klen_type;

   typedef struct packed {
      logic                      kind;
      logic [PREFIX_COUNT_W-1:0] count;
   } answer_type;

   typedef struct packed {
      chars_type letters;
      klen_type  span;
   } word_type;

   logic clock;
   logic reset;

   tpc_req_if req_bus ();
   tpc_rsp_if rsp_bus ();

   trie_prefix_counter_core dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_bus),
      .rsp_if (rsp_bus)
   );

   // Trie copy: child links, pass counts and the allocation cursor.
   logic [LINK_W-1:0]           trie_links [NODES*ALPHA];
   logic [COUNT_WIDTH_DEFAULT-1:0] node_tally [NODES];
   int                          free_cursor;

   answer_type pending_answers [$];   // answers owed by the core, oldest first
   word_type   stored_words [$];      // keys known to be in the trie

   int error_count;
   int quiet_cycles;
   int hold_request;
   bit gap_enable;
   bit stall_enable;
   bit req_up;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // Trie copy
   // ---------------------------------------------------------------------

   function automatic int letter_of(chars_type chars, int i);
      return int'(chars[LETTER_BITS*i +: LETTER_BITS]);
   endfunction

   function automatic int nodes_free();
      return (free_cursor < NODES) ? NODES - free_cursor : 0;
   endfunction

   // Applies one accepted item. Returns 1 when an insert was stored.
   function automatic bit trie_apply(logic mode, chars_type chars, klen_type len_in);
      int         len;
      int         node;
      int         li;
      bit         letters_ok;
      bit         broken;
      answer_type ans;
      len = (len_in > MAX_LEN) ? MAX_LEN : int'(len_in);   // long lengths saturate
      letters_ok = 1'b1;
      for (int i = 0; i < len; i++)
         if (letter_of(chars, i) >= ALPHA) letters_ok = 1'b0;
      node = 0;
      if (mode == MODE_INSERT) begin
         // zero length or a bad letter: silently dropped
         if (len == 0 || !letters_ok) return 1'b0;
         // not enough room for the whole key, even if its path exists
         if (nodes_free() < len) begin
            ans.kind  = KIND_REJECT;
            ans.count = '0;
            pending_answers = {pending_answers, ans};
            return 1'b0;
         end
         for (int i = 0; i < len; i++) begin
            li = node * ALPHA + letter_of(chars, i);
            if (trie_links[li] == '0) begin
               trie_links[li]          = LINK_W'(free_cursor);
               node_tally[free_cursor] = COUNT_WIDTH_DEFAULT'(1);
               node                    = free_cursor;
               free_cursor++;
            end else begin
               node = int'(trie_links[li]);
               if (node_tally[node] != TALLY_MAX) node_tally[node]++;
            end
         end
         return 1'b1;
      end
      ans.kind  = KIND_ANSWER;
      ans.count = '0;
      broken    = 1'b0;
      if (len != 0 && letters_ok) begin
         for (int i = 0; i < len; i++)
            if (!broken) begin
               node = int'(trie_links[node * ALPHA + letter_of(chars, i)]);
               if (node == 0) broken = 1'b1;
            end
         if (!broken) ans.count = node_tally[node];
      end
      pending_answers = {pending_answers, ans};
      return 1'b0;
   endfunction

   // ---------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------

   // Mostly back to back, some short gaps, a few long ones.
   function automatic int pick_gap(bit enabled);
      int r;
      if (!enabled) return 0;
      r = $urandom_range(99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(3, 1);
      if (r < 97) return $urandom_range(12, 4);
      return $urandom_range(60, 20);
   endfunction

   function automatic chars_type noise_chars();
      return chars_type'({$urandom, $urandom});
   endfunction

   // Keeps the first keep letters of base, the rest random in 0..hi.
   function automatic chars_type extend_word(chars_type base, int keep, int hi);
      chars_type w;
      w = base;
      for (int i = keep; i < MAX_LEN; i++)
         w[LETTER_BITS*i +: LETTER_BITS] = LETTER_BITS'($urandom_range(hi));
      return w;
   endfunction

   // A full-length key now and then goes out with a length above the maximum.
   function automatic klen_type stretch_len(int len);
      if (len == MAX_LEN && $urandom_range(3) == 0)
         return klen_type'($urandom_range(LEN_TOP, MAX_LEN + 1));
      return klen_type'(len);
   endfunction

   function automatic void pick_query(output chars_type chars, output klen_type len);
      word_type w;
      int       span;
      int       pos;
      int       r;
      r = $urandom_range(99);
      if (r < 15 || stored_words.size() == 0) begin
         chars = noise_chars();
         len   = klen_type'($urandom_range(LEN_TOP));
         return;
      end
      w     = stored_words[$urandom_range(stored_words.size() - 1)];
      span  = $urandom_range(int'(w.span), 1);
      chars = w.letters;
      if (r < 30) begin
         // one letter changed: usually a broken path
         pos = $urandom_range(span - 1);
         chars[LETTER_BITS*pos +: LETTER_BITS] = LETTER_BITS'($urandom_range(ALPHA - 1));
      end
      chars = extend_word(chars, span, LETTER_TOP);   // junk past the prefix
      len   = stretch_len(span);
   endfunction

   function automatic void pick_insert(output chars_type chars, output klen_type len);
      word_type w;
      int       keep;
      int       span;
      int       r;
      r = $urandom_range(99);
      if (r < 8 || stored_words.size() == 0) begin
         chars = noise_chars();
         len   = klen_type'($urandom_range(LEN_TOP));
         return;
      end
      w = stored_words[$urandom_range(stored_words.size() - 1)];
      if (r < 30 && nodes_free() > POOL_RESERVE) begin
         span  = $urandom_range(MAX_LEN, 1);
         chars = extend_word('0, 0, ALPHA - 1);
      end else if (r < 55 && nodes_free() > POOL_RESERVE) begin
         // grow a stored key; a narrow alphabet keeps branches shared
         keep  = $urandom_range(int'(w.span), 1);
         span  = $urandom_range(MAX_LEN, keep);
         chars = extend_word(w.letters, keep, 3);
      end else begin
         // stored key or one of its prefixes again
         span  = $urandom_range(int'(w.span), 1);
         chars = w.letters;
      end
      chars = extend_word(chars, span, LETTER_TOP);
      len   = stretch_len(span);
   endfunction

   // One req transfer. valid stays up between back-to-back items.
   task automatic send_item(logic mode, chars_type chars, klen_type len);
      int       gap;
      klen_type span;
      gap = pick_gap(gap_enable);
      if (gap > 0) begin
         if (req_up) req_bus.valid <= 1'b0;
         req_up = 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.mode       <= mode;
      req_bus.key_chars  <= chars;
      req_bus.key_length <= len;
      req_up = 1'b1;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      span = (len > MAX_LEN) ? klen_type'(MAX_LEN) : len;
      if (trie_apply(mode, chars, len) && stored_words.size() < WORD_CAP)
         stored_words = {stored_words, word_type'{letters: chars, span: span}};
   endtask

   task automatic req_idle();
      if (req_up) begin
         req_bus.valid <= 1'b0;
         req_up = 1'b0;
         @(posedge clock);
      end
   endtask

   task automatic wait_answers_drained();
      req_idle();
      while (pending_answers.size() != 0) @(posedge clock);
   endtask

   task automatic report_mismatch(string what);
      if (error_count < 50) $display("[%0t] %s", $time, what);
      error_count++;
   endtask

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------

   // Right after the clearing sweep every prefix misses.
   task automatic test_empty_trie();
      gap_enable   = 1'b0;
      stall_enable = 1'b0;
      send_item(MODE_QUERY, '0, klen_type'(1));
      send_item(MODE_QUERY, chars_type'(ALPHA - 1), klen_type'(1));
      send_item(MODE_QUERY, extend_word('0, 0, ALPHA - 1), klen_type'(MAX_LEN));
      send_item(MODE_QUERY, extend_word('0, 0, ALPHA - 1),
                klen_type'($urandom_range(MAX_LEN, 1)));
   endtask

   task automatic test_directed_keys();
      chars_type all_a;
      chars_type all_z;
      chars_type ones;
      chars_type bad_tail;
      chars_type mixed;
      chars_type broken_mid;
      all_a = '0;
      all_z = '0;
      ones  = '1;
      for (int i = 0; i < MAX_LEN; i++)
         all_z[LETTER_BITS*i +: LETTER_BITS] = LETTER_BITS'(ALPHA - 1);
      bad_tail = all_z;
      // first code past the alphabet
      bad_tail[LETTER_BITS*(MAX_LEN-1) +: LETTER_BITS] = LETTER_BITS'(ALPHA);
      mixed = ones;
      mixed[3*LETTER_BITS-1:0] = {5'd2, 5'd1, 5'd0};               // "abc", junk after
      broken_mid = all_a;
      broken_mid[LETTER_BITS*5 +: LETTER_BITS] = LETTER_BITS'(1);
      gap_enable   = 1'b0;
      stall_enable = 1'b0;

      send_item(MODE_INSERT, all_a, klen_type'(1));
      send_item(MODE_INSERT, all_z, klen_type'(MAX_LEN));
      send_item(MODE_INSERT, all_a, klen_type'(MAX_LEN));
      send_item(MODE_INSERT, all_z, klen_type'(LEN_TOP));       // length saturates
      send_item(MODE_INSERT, ones, '0);                          // zero length, silent
      send_item(MODE_INSERT, ones, klen_type'(LEN_TOP));         // bad letters, silent
      send_item(MODE_INSERT, bad_tail, klen_type'(MAX_LEN));     // bad last letter, silent
      send_item(MODE_INSERT, bad_tail, klen_type'(MAX_LEN - 1)); // bad letter unused
      send_item(MODE_INSERT, mixed, klen_type'(3));
      send_item(MODE_QUERY, all_z, klen_type'(1));
      send_item(MODE_QUERY, all_z, klen_type'(MAX_LEN));
      send_item(MODE_QUERY, all_z, klen_type'(LEN_TOP));
      send_item(MODE_QUERY, bad_tail, klen_type'(MAX_LEN));
      send_item(MODE_QUERY, ones, '0);
      send_item(MODE_QUERY, ones, klen_type'(LEN_TOP));
      send_item(MODE_QUERY, all_a, klen_type'(1));
      send_item(MODE_QUERY, all_a, klen_type'(MAX_LEN));
      send_item(MODE_QUERY, chars_type'(1), klen_type'(1));      // missing first letter
      send_item(MODE_QUERY, broken_mid, klen_type'(MAX_LEN));    // path breaks midway
      send_item(MODE_QUERY, mixed, klen_type'(2));
      send_item(MODE_QUERY, mixed, klen_type'(3));
   endtask

   task automatic test_random_traffic();
      chars_type chars;
      klen_type  len;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         // stretches with both gaps and stalls, with gaps only, and with stalls only
         if (n % 150 == 0) begin
            gap_enable   = ((n / 150) % 3) != 2;
            stall_enable = ((n / 150) % 3) != 1;
         end
         if ($urandom_range(99) < 40) begin
            pick_query(chars, len);
            send_item(MODE_QUERY, chars, len);
         end else begin
            pick_insert(chars, len);
            send_item(MODE_INSERT, chars, len);
         end
      end
   endtask

   // rsp held off while queries keep coming: the result register fills and
   // req_ready must drop. Then the sender waits for every answer.
   task automatic test_result_stall();
      chars_type chars;
      klen_type  len;
      gap_enable   = 1'b0;
      stall_enable = 1'b0;
      hold_request = HOLD_CYCLES;
      for (int k = 0; k < 16; k++) begin
         pick_query(chars, len);
         send_item(MODE_QUERY, chars, len);
      end
      wait_answers_drained();
      for (int k = 0; k < 8; k++) begin
         pick_query(chars, len);
         send_item(MODE_QUERY, chars, len);
      end
   endtask

   // One single-letter key inserted again and again, then a child under it.
   task automatic test_count_growth();
      chars_type hot_key;
      gap_enable   = 1'b0;
      stall_enable = 1'b0;
      hot_key = extend_word(chars_type'(ALPHA - 1), 1, LETTER_TOP);
      repeat (COUNT_REPEAT) send_item(MODE_INSERT, hot_key, klen_type'(1));
      send_item(MODE_QUERY, hot_key, klen_type'(1));
      hot_key[2*LETTER_BITS-1:LETTER_BITS] = LETTER_BITS'(ALPHA - 2);
      send_item(MODE_INSERT, hot_key, klen_type'(2));            // parent count bumps too
      send_item(MODE_QUERY, hot_key, klen_type'(1));
      send_item(MODE_QUERY, hot_key, klen_type'(2));
   endtask

   task automatic test_pool_exhaustion();
      chars_type chars;
      klen_type  len;
      word_type  w;
      int        guard;
      gap_enable   = 1'b1;
      stall_enable = 1'b1;
      guard = 0;
      // all-a full-length key, stored by the directed test
      w = '{letters: '0, span: klen_type'(MAX_LEN)};
      while (nodes_free() >= MAX_LEN && guard < 500) begin
         guard++;
         send_item(MODE_INSERT, extend_word('0, 0, ALPHA - 1), klen_type'(MAX_LEN));
         if ($urandom_range(3) == 0) begin
            pick_query(chars, len);
            send_item(MODE_QUERY, chars, len);
         end
      end
      // fewer free nodes than letters: turned away even though the path exists
      foreach (stored_words[i])
         if (stored_words[i].span == MAX_LEN) w = stored_words[i];
      send_item(MODE_INSERT, w.letters, w.span);
      send_item(MODE_QUERY, w.letters, w.span);
      // lengths on both sides of the remaining room
      for (int k = 0; k < 40; k++) begin
         if ($urandom_range(1) == 1) begin
            len = klen_type'($urandom_range(MAX_LEN, 1));
            send_item(MODE_INSERT, extend_word('0, 0, ALPHA - 1), len);
         end else begin
            pick_query(chars, len);
            send_item(MODE_QUERY, chars, len);
         end
      end
      // length and letter checks come before the room check
      send_item(MODE_INSERT, '1, '0);
      send_item(MODE_INSERT, '1, klen_type'(1));
      send_item(MODE_INSERT, w.letters, w.span);
   endtask

   // ---------------------------------------------------------------------
   // rsp side: random stalls, plus the long hold-off on request
   // ---------------------------------------------------------------------
   initial begin : rsp_pacing
      int stall_left;
      int hold_left;
      stall_left = 0;
      hold_left  = 0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request > 0) begin
            hold_left    = hold_request;
            hold_request = 0;
         end
         if (hold_left > 0) begin
            rsp_bus.ready <= 1'b0;
            hold_left--;
         end else if (stall_left > 0) begin
            rsp_bus.ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_bus.ready <= 1'b1;
            if (stall_enable && $urandom_range(5) == 0) stall_left = pick_gap(1'b1);
         end
      end
   end

   // Every rsp transfer against the oldest owed answer.
   always @(posedge clock) begin : answer_check
      answer_type want;
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         if (pending_answers.size() == 0) begin
            report_mismatch($sformatf("unexpected result kind=%0b count=%0d",
                                      rsp_bus.kind, rsp_bus.prefix_count));
         end else begin
            want = pending_answers.pop_front();
            if (rsp_bus.kind !== want.kind)
               report_mismatch($sformatf("kind %0b, expected %0b",
                                         rsp_bus.kind, want.kind));
            if (rsp_bus.prefix_count !== want.count)
               report_mismatch($sformatf("prefix_count %0d, expected %0d",
                                         rsp_bus.prefix_count, want.count));
         end
      end
   end

   // Watchdog: too long with no transfer on either channel.
   always @(posedge clock) begin
      if ((req_bus.valid === 1'b1 && req_bus.ready === 1'b1) ||
          (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == QUIET_LIMIT) begin
         $display("trie_prefix_counter_core: mismatch");
         $finish;
      end
   end

   initial begin
      reset              <= 1'b1;
      req_bus.valid      <= 1'b0;
      req_bus.mode       <= MODE_INSERT;
      req_bus.key_chars  <= '0;
      req_bus.key_length <= '0;
      foreach (trie_links[i]) trie_links[i] = '0;
      free_cursor  = 1;
      error_count  = 0;
      quiet_cycles = 0;
      hold_request = 0;
      gap_enable   = 1'b0;
      stall_enable = 1'b0;
      req_up       = 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // req_ready stays low through the clearing sweep; send_item waits it out.
      test_empty_trie();
      test_directed_keys();
      test_random_traffic();
      test_result_stall();
      test_count_growth();
      test_pool_exhaustion();

      wait_answers_drained();
      repeat (60) @(posedge clock);
      if (error_count == 0)
         $display("trie_prefix_counter_core: match");
      else
         $display("trie_prefix_counter_core: mismatch");
      $finish;
   end

endmodule

FILE: files.f
rtl/tpc_pkg.sv
rtl/tpc_if.sv
rtl/tpc_ram.sv
rtl/tpc_ctrl.sv
rtl/tpc_datapath.sv
rtl/trie_prefix_counter_core.sv
rtl/tpc_checker.sv
sim/tb_top.sv
